// File: design/assert_macros.svh
// Assertion macros shared by the detection box decode design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DBD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("Assertion lbl failed.");

// Next-cycle implication, checked outside reset.
`define DBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("Assertion lbl failed.");

`endif

// File: design/dbd_pkg.sv
// Shared types and constants of the detection box decode core.
package dbd_pkg;

  localparam int unsigned FieldW    = 16;
  localparam int unsigned DimW      = 13;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned MaxClass  = 4;
  localparam int unsigned CornerW   = FieldW + 1;
  localparam int unsigned DiffW     = CornerW + 1;
  localparam int unsigned GainW     = FieldW + 1;
  localparam int unsigned ProdW     = DiffW + GainW;
  localparam int unsigned FracShift = 12;
  localparam int unsigned ScaledW   = ProdW - FracShift;
  localparam int unsigned InDataW   = 8 * FieldW;
  localparam int unsigned OutDataW  = 88;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_INVERSE_GAIN    = 3'd1,
    REG_PAD_X           = 3'd2,
    REG_PAD_Y           = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic load_diff;
    logic load_prod;
  } lane_ctrl_t;

endpackage

// File: design/dbd_class_pick.sv
// Best class selection and score threshold test for one anchor.
module dbd_class_pick
  import dbd_pkg::*;
#(
  parameter int unsigned NumClasses = 3
) (
  input  logic [MaxClass-1:0][FieldW-1:0] scores_i,
  input  logic [FieldW-1:0]               threshold_i,
  output logic [FieldW-1:0]               top_score_o,
  output logic [IdxW-1:0]                 best_idx_o,
  output logic                            keep_o
);

  always_comb begin
    top_score_o = scores_i[0];
    best_idx_o  = '0;
    for (int c = 1; c < MaxClass; c++) begin
      if ((c < NumClasses) && (scores_i[c] > top_score_o)) begin
        top_score_o = scores_i[c];
        best_idx_o  = IdxW'(c);
      end
    end
    keep_o = (top_score_o >= threshold_i);
  end

endmodule

// File: design/dbd_corner_lane.sv
// One corner lane: pad subtraction, gain multiply, floor and clamp to the image.
module dbd_corner_lane
  import dbd_pkg::*;
(
  input  logic                      clk_i,
  input  lane_ctrl_t                ctrl_i,
  input  logic signed [CornerW-1:0] corner_i,
  input  logic signed [FieldW-1:0]  pad_i,
  input  logic [FieldW-1:0]         gain_i,
  input  logic [DimW-1:0]           dim_i,
  output logic [FieldW-1:0]         edge_o
);

  logic signed [DiffW-1:0]   diff_d, diff_q;
  logic signed [ProdW-1:0]   prod_d, prod_q;
  logic signed [GainW-1:0]   gain_s;
  logic signed [ScaledW-1:0] scaled;
  logic signed [ScaledW-1:0] upper;
  logic signed [ScaledW-1:0] bounded;

  assign diff_d = DiffW'(corner_i) - DiffW'(pad_i);
  assign gain_s = $signed({1'b0, gain_i});
  assign prod_d = ProdW'(diff_q) * ProdW'(gain_s);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_diff) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.load_prod) begin
      prod_q <= prod_d;
    end
  end

  // Dropping the low bits of the signed product floors toward minus infinity.
  assign scaled = prod_q[ProdW-1:FracShift];
  assign upper  = ($signed({{(ScaledW-DimW){1'b0}}, dim_i}) - ScaledW'(1)) <<< 4;

  always_comb begin
    bounded = (scaled > upper) ? upper : scaled;
    if (bounded < 0) begin
      edge_o = '0;
    end else if (bounded > $signed(ScaledW'(17'h0FFFF))) begin
      edge_o = '1;
    end else begin
      edge_o = bounded[FieldW-1:0];
    end
  end

endmodule

// File: design/detection_box_decode_core.sv
// Latency: a result beat passes the difference, product and output registers after its anchor
// beat is accepted. Throughput: one anchor per cycle while the output is not stalled; each
// of the four corner lanes registers its difference and its product, and clamps combinationally.
// Reset: asynchronous, active low; the pipeline empties and the configuration
// registers return to their default values.
module detection_box_decode_core
  import dbd_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // center_x, center_y, box_width, box_height, score_0 .. score_3
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // left_edge, top_edge, right_edge, bottom_edge, confidence, class_index, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [FieldW-1:0]   cfg_data_i
);

  logic [FieldW-1:0] threshold_q, gain_q;
  logic signed [FieldW-1:0] pad_x_q, pad_y_q;
  logic [DimW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 16'd16384;
      gain_q      <= 16'd4096;
      pad_x_q     <= 16'sd0;
      pad_y_q     <= -16'sd64;
      width_q     <= 13'd640;
      height_q    <= 13'd352;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SCORE_THRESHOLD: threshold_q <= cfg_data_i;
        REG_INVERSE_GAIN:    gain_q      <= cfg_data_i;
        REG_PAD_X:           pad_x_q     <= cfg_data_i;
        REG_PAD_Y:           pad_y_q     <= cfg_data_i;
        REG_IMAGE_WIDTH:     width_q     <= cfg_data_i[DimW-1:0];
        REG_IMAGE_HEIGHT:    height_q    <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [FieldW-1:0] cx, cy, bw, bh, hw, hh;
  logic [MaxClass-1:0][FieldW-1:0] scores;
  logic signed [CornerW-1:0] corner [4];

  assign cx     = s_axis_tdata[0*FieldW +: FieldW];
  assign cy     = s_axis_tdata[1*FieldW +: FieldW];
  assign bw     = s_axis_tdata[2*FieldW +: FieldW];
  assign bh     = s_axis_tdata[3*FieldW +: FieldW];
  assign scores = s_axis_tdata[4*FieldW +: MaxClass*FieldW];
  assign hw     = bw >>> 1;
  assign hh     = bh >>> 1;

  assign corner[0] = CornerW'(cx) - CornerW'(hw);
  assign corner[1] = CornerW'(cy) - CornerW'(hh);
  assign corner[2] = CornerW'(cx) + CornerW'(hw);
  assign corner[3] = CornerW'(cy) + CornerW'(hh);

  logic [FieldW-1:0] top_score;
  logic [IdxW-1:0]   best_idx;
  logic              keep;

  dbd_class_pick #(
    .NumClasses(CLASS_COUNT)
  ) u_class_pick (
    .scores_i    (scores),
    .threshold_i (threshold_q),
    .top_score_o (top_score),
    .best_idx_o  (best_idx),
    .keep_o      (keep)
  );

  logic s1_valid_q, s1_keep_q, s2_valid_q, s2_keep_q, out_valid_q;
  logic [FieldW-1:0] s1_score_q, s2_score_q;
  logic [IdxW-1:0]   s1_idx_q, s2_idx_q;
  logic out_free, s2_free, s1_free, accept, adv2, adv3, load_out;

  assign out_free = !out_valid_q || m_axis_tready;
  assign s2_free  = !s2_valid_q || !s2_keep_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign accept   = s_axis_tvalid && s1_free;
  assign adv2     = s1_valid_q && s2_free;
  assign adv3     = s2_valid_q && (!s2_keep_q || out_free);
  assign load_out = adv3 && s2_keep_q;
  assign s_axis_tready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= load_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_keep_q  <= keep;
      s1_score_q <= top_score;
      s1_idx_q   <= best_idx;
    end
    if (adv2) begin
      s2_keep_q  <= s1_keep_q;
      s2_score_q <= s1_score_q;
      s2_idx_q   <= s1_idx_q;
    end
  end

  lane_ctrl_t lane_ctrl;
  logic [FieldW-1:0] lane_edge [4];

  assign lane_ctrl.load_diff = accept;
  assign lane_ctrl.load_prod = adv2;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    dbd_corner_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .corner_i(corner[l]),
      .pad_i   ((l % 2 == 0) ? pad_x_q : pad_y_q),
      .gain_i  (gain_q),
      .dim_i   ((l % 2 == 0) ? width_q : height_q),
      .edge_o  (lane_edge[l])
    );
  end

  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {{(OutDataW - 5*FieldW - IdxW){1'b0}}, s2_idx_q, s2_score_q,
                     lane_edge[3], lane_edge[2], lane_edge[1], lane_edge[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`include "assert_macros.svh"

  `DBD_ASSERT_NEXT(a_out_from_kept, clk_i, rst_ni, load_out, out_valid_q)
  `DBD_ASSERT_IMPLIES(a_stall_full, clk_i, rst_ni, !s_axis_tready,
                      s1_valid_q && s2_valid_q && s2_keep_q && out_valid_q)
  `DBD_ASSERT_IMPLIES(a_class_range, clk_i, rst_ni, out_valid_q,
                      32'(out_data_q[5*FieldW +: IdxW]) < CLASS_COUNT)
  `DBD_ASSERT_NEXT(a_drop_no_out, clk_i, rst_ni,
                   adv3 && !s2_keep_q && !out_valid_q, !out_valid_q)

endmodule

// File: dv/detection_box_decode_core_test.sv
// Self-checking testbench for the detection box decode core, with its own box predictor.
`timescale 1ns / 1ps

module detection_box_decode_core_test;
  import dbd_pkg::*;

  localparam int unsigned NumClasses   = 3;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldCycles   = 100;
  localparam int unsigned MaxPrinted   = 40;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  // The last member sits in the lowest bits, so these match the packed beats.
  typedef struct packed {
    logic        [FieldW-1:0] score_3;
    logic        [FieldW-1:0] score_2;
    logic        [FieldW-1:0] score_1;
    logic        [FieldW-1:0] score_0;
    logic signed [FieldW-1:0] box_height;
    logic signed [FieldW-1:0] box_width;
    logic signed [FieldW-1:0] center_y;
    logic signed [FieldW-1:0] center_x;
  } anchor_t;

  typedef struct packed {
    logic [OutDataW-5*FieldW-IdxW-1:0] fill;
    logic [IdxW-1:0]                   class_index;
    logic [FieldW-1:0]                 confidence;
    logic [FieldW-1:0]                 bottom_edge;
    logic [FieldW-1:0]                 right_edge;
    logic [FieldW-1:0]                 top_edge;
    logic [FieldW-1:0]                 left_edge;
  } box_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [FieldW-1:0]   cfg_data_i = '0;

  logic        [FieldW-1:0] threshold_q = 16'd16384;
  logic        [FieldW-1:0] gain_q = 16'd4096;
  logic signed [FieldW-1:0] pad_x_q = 16'sd0;
  logic signed [FieldW-1:0] pad_y_q = -16'sd64;
  logic        [DimW-1:0]   width_q = 13'd640;
  logic        [DimW-1:0]   height_q = 13'd352;

  box_t        pending_boxes[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  bit          send_bursty = 1'b1;
  bit          rx_steady = 1'b0;
  int unsigned rx_hold_len = 0;
  int unsigned rx_hold_seq = 0;
  int unsigned rx_seen_seq = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_run_left = 0;
  bit          rx_run_ready = 1'b0;

  detection_box_decode_core #(
    .CLASS_COUNT(NumClasses)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [FieldW-1:0] map_corner(longint corner, longint pad, longint dim);
    longint scaled;
    scaled = ((corner - pad) * longint'(gain_q)) >>> FracShift;
    if (scaled > (dim - 1) * 16) scaled = (dim - 1) * 16;
    if (scaled < 0) scaled = 0;
    if (scaled > 65535) scaled = 65535;
    return scaled[FieldW-1:0];
  endfunction

  function automatic bit predict_box(input anchor_t a, output box_t b);
    logic [FieldW-1:0] scores [MaxClass];
    logic [FieldW-1:0] best;
    logic [IdxW-1:0]   best_idx;
    longint            half_w;
    longint            half_h;
    scores = '{a.score_0, a.score_1, a.score_2, a.score_3};
    best = scores[0];
    best_idx = '0;
    b = '0;
    for (int c = 1; c < NumClasses && c < MaxClass; c++) begin
      if (scores[c] > best) begin
        best = scores[c];
        best_idx = IdxW'(c);
      end
    end
    if (best < threshold_q) return 1'b0;
    half_w = longint'(a.box_width) >>> 1;
    half_h = longint'(a.box_height) >>> 1;
    b.left_edge   = map_corner(longint'(a.center_x) - half_w, longint'(pad_x_q), longint'(width_q));
    b.top_edge    = map_corner(longint'(a.center_y) - half_h, longint'(pad_y_q), longint'(height_q));
    b.right_edge  = map_corner(longint'(a.center_x) + half_w, longint'(pad_x_q), longint'(width_q));
    b.bottom_edge = map_corner(longint'(a.center_y) + half_h, longint'(pad_y_q), longint'(height_q));
    b.confidence  = best;
    b.class_index = best_idx;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [OutDataW-1:0] want,
                                 input logic [OutDataW-1:0] got);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("tb: %s mismatch at %0t: expected %0h, got %0h", what, $time, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    box_t want;
    box_t got;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SCORE_THRESHOLD: threshold_q = cfg_data_i;
        REG_INVERSE_GAIN:    gain_q = cfg_data_i;
        REG_PAD_X:           pad_x_q = cfg_data_i;
        REG_PAD_Y:           pad_y_q = cfg_data_i;
        REG_IMAGE_WIDTH:     width_q = cfg_data_i[DimW-1:0];
        REG_IMAGE_HEIGHT:    height_q = cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      if (predict_box(anchor_t'(s_axis_tdata), want)) pending_boxes = {pending_boxes, want};
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = box_t'(m_axis_tdata);
      if (pending_boxes.size() == 0) begin
        report_mismatch("unexpected box", '0, m_axis_tdata);
      end else begin
        want = pending_boxes.pop_front();
        if (got.left_edge !== want.left_edge)
          report_mismatch("left_edge", OutDataW'(want.left_edge), OutDataW'(got.left_edge));
        if (got.top_edge !== want.top_edge)
          report_mismatch("top_edge", OutDataW'(want.top_edge), OutDataW'(got.top_edge));
        if (got.right_edge !== want.right_edge)
          report_mismatch("right_edge", OutDataW'(want.right_edge), OutDataW'(got.right_edge));
        if (got.bottom_edge !== want.bottom_edge)
          report_mismatch("bottom_edge", OutDataW'(want.bottom_edge),
                          OutDataW'(got.bottom_edge));
        if (got.confidence !== want.confidence)
          report_mismatch("confidence", OutDataW'(want.confidence), OutDataW'(got.confidence));
        if (got.class_index !== want.class_index)
          report_mismatch("class_index", OutDataW'(want.class_index),
                          OutDataW'(got.class_index));
        if (got.fill !== want.fill)
          report_mismatch("zero fill", OutDataW'(want.fill), OutDataW'(got.fill));
      end
    end
  end

  // The receiver either runs free, stalls in random stretches, or holds off on request.
  always @(negedge clk_i) begin
    if (rx_hold_seq != rx_seen_seq) begin
      rx_seen_seq = rx_hold_seq;
      rx_hold_left = rx_hold_len;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_run_ready = !rx_run_ready;
        rx_run_left = rx_run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      rx_run_left--;
      m_axis_tready <= rx_run_ready;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  function automatic anchor_t make_anchor(int cx, int cy, int w, int h,
                                          int s0, int s1, int s2, int s3);
    anchor_t a;
    a.center_x = cx[FieldW-1:0];
    a.center_y = cy[FieldW-1:0];
    a.box_width = w[FieldW-1:0];
    a.box_height = h[FieldW-1:0];
    a.score_0 = s0[FieldW-1:0];
    a.score_1 = s1[FieldW-1:0];
    a.score_2 = s2[FieldW-1:0];
    a.score_3 = s3[FieldW-1:0];
    return a;
  endfunction

  // Most anchors are plausible boxes whose best score is at least the threshold or just below it.
  function automatic anchor_t random_anchor();
    anchor_t     a;
    logic [FieldW-1:0] top;
    int unsigned room;
    a = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) < 7) begin
      a.center_x = FieldW'($urandom_range(0, 12000));
      a.center_y = FieldW'($urandom_range(0, 8000));
      a.box_width = FieldW'($urandom_range(0, 4000));
      a.box_height = FieldW'($urandom_range(0, 4000));
      if ($urandom_range(0, 9) == 0) a.box_width = -a.box_width;
      if ($urandom_range(0, 9) == 0) a.box_height = -a.box_height;
      room = 65535 - threshold_q;
      top = FieldW'(threshold_q + $urandom_range(0, room));
      if ($urandom_range(0, 4) == 0 && threshold_q != 0) top = threshold_q - 1;
      a.score_0 = FieldW'($urandom_range(0, top));
      a.score_1 = FieldW'($urandom_range(0, top));
      a.score_2 = FieldW'($urandom_range(0, top));
      case ($urandom_range(0, 2))
        0: a.score_0 = top;
        1: a.score_1 = top;
        default: a.score_2 = top;
      endcase
      if ($urandom_range(0, 3) == 0) a.score_1 = top;
    end
    return a;
  endfunction

  task automatic send_anchor(input anchor_t a);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (send_bursty && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [FieldW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Dropped anchors leave no expectation, so settle past the pipeline depth too.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_anchor(random_anchor());
  endtask

  task automatic send_extremes();
    send_anchor(make_anchor(32767, 32767, 32767, 32767, 65535, 0, 0, 0));
    send_anchor(make_anchor(-32768, -32768, -32768, -32768, 0, 65535, 0, 0));
    send_anchor(make_anchor(-1, -1, -1, -1, 65535, 65535, 65535, 65535));
    send_anchor(make_anchor(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_directed_anchors();
    send_bursty = 1'b0;
    rx_steady = 1'b1;
    send_anchor(make_anchor(1600, 1600, 320, 320, 0, 0, 0, 0));
    send_anchor(make_anchor(1600, 1600, 320, 320, 16384, 0, 0, 0));
    send_anchor(make_anchor(1600, 1600, 320, 320, 16383, 16383, 16383, 65535));
    send_anchor(make_anchor(1600, 1600, 320, 320, 40000, 40000, 40000, 0));
    send_anchor(make_anchor(1600, 1600, 320, 320, 100, 50000, 50000, 0));
    send_anchor(make_anchor(1600, 1600, 320, 320, 100, 200, 65535, 65535));
    send_anchor(make_anchor(0, 0, -1, -1, 30000, 0, 0, 0));
    send_anchor(make_anchor(5, 5, 3, 3, 30000, 0, 0, 0));
    send_anchor(make_anchor(10224, 5616, 0, 0, 20000, 0, 0, 0));
    send_anchor(make_anchor(10240, 5632, 64, 64, 20000, 0, 0, 0));
    send_anchor(make_anchor(-100, -100, 50, 50, 20000, 0, 0, 0));
    send_anchor(make_anchor(320, -64, 32, 32, 0, 0, 20000, 0));
    send_extremes();
    wait_drained();
  endtask

  task automatic test_register_settings();
    send_bursty = 1'b1;
    rx_steady = 1'b0;
    // Everything is kept and a zero gain pulls every corner to zero.
    write_reg(REG_SCORE_THRESHOLD, 16'd0);
    write_reg(REG_INVERSE_GAIN, 16'd0);
    write_reg(REG_PAD_X, 16'd0);
    write_reg(REG_PAD_Y, 16'd0);
    send_extremes();
    send_random(16);
    wait_drained();
    // Highest threshold, zero image width and a height above the clamp range.
    write_reg(REG_SCORE_THRESHOLD, 16'hFFFF);
    write_reg(REG_INVERSE_GAIN, 16'hFFFF);
    write_reg(REG_PAD_X, 16'h7FFF);
    write_reg(REG_PAD_Y, 16'h8000);
    write_reg(REG_IMAGE_WIDTH, 16'h0000);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    send_extremes();
    send_random(16);
    wait_drained();
    write_reg(REG_SCORE_THRESHOLD, 16'd1);
    write_reg(REG_INVERSE_GAIN, 16'd1);
    write_reg(REG_PAD_X, 16'h8000);
    write_reg(REG_PAD_Y, 16'h7FFF);
    write_reg(REG_IMAGE_WIDTH, 16'd4096);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    send_extremes();
    send_random(16);
    wait_drained();
    // Writes to unused indexes must leave every register alone.
    write_reg(REG_SCORE_THRESHOLD, 16'd16384);
    write_reg(REG_INVERSE_GAIN, 16'd8192);
    write_reg(REG_IMAGE_WIDTH, 16'd4097);
    write_reg(REG_IMAGE_HEIGHT, 16'hE001);
    write_reg(RegSpareLo, 16'($urandom));
    write_reg(RegSpareHi, 16'($urandom));
    send_extremes();
    send_random(16);
    wait_drained();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 5; phase++) begin
      send_bursty = ($urandom_range(0, 3) != 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      write_reg(REG_SCORE_THRESHOLD, 16'($urandom_range(0, 40000)));
      write_reg(REG_INVERSE_GAIN, 16'($urandom_range(1024, 12288)));
      write_reg(REG_PAD_X, 16'(int'($urandom_range(0, 4000)) - 2000));
      write_reg(REG_PAD_Y, 16'(int'($urandom_range(0, 4000)) - 2000));
      write_reg(REG_IMAGE_WIDTH,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096)));
      write_reg(REG_IMAGE_HEIGHT,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096)));
      send_random(200);
      wait_drained();
    end
  endtask

  // The sender keeps offering beats while the receiver holds off, so the core backs up.
  task automatic test_backpressure();
    send_bursty = 1'b0;
    rx_steady = 1'b1;
    write_reg(REG_SCORE_THRESHOLD, 16'd0);
    write_reg(REG_INVERSE_GAIN, 16'd4096);
    rx_hold_len = HoldCycles;
    rx_hold_seq++;
    send_random(60);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_anchors();
    test_register_settings();
    test_random_stream();
    test_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
